### design/bsdt_pkg.sv
package bsdt_pkg;

  localparam int RPM_W      = 12;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int SPEED_W    = 26;
  localparam int DIST_W     = 48;
  localparam int TIME_W     = 32;
  localparam int QUOT_W     = 16;
  localparam int STEP_CNT_W = 4;
  localparam int RPM60_W    = RPM_W + 6;
  localparam int PROD_W     = RPM60_W + CFG_W;
  localparam int SPEED_SHIFT = 8;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_DIST_PER_REV = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_FALL   = 2'd2;

  localparam logic [CFG_W-1:0] DIST_PER_REV_RST = 16'd13307;
  localparam logic [CFG_W-1:0] TIMEOUT_MS_RST   = 16'd3000;
  localparam logic [CFG_W-1:0] SPEED_FALL_RST   = 16'd33;

  localparam logic [QUOT_W-1:0]  MS_PER_MINUTE = 16'd60000;
  localparam logic [RPM60_W-1:0] MIN_PER_HOUR  = 18'd60;

  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_REV  = 1'b1;

  typedef struct packed {
    logic capture;
    logic tick;
    logic rev;
    logic div_step;
    logic commit;
    logic publish;
  } bsdt_cmd_t;

  typedef struct packed {
    logic mode;
    logic late;
    logic div_last;
    logic out_free;
  } bsdt_status_t;

endpackage

### design/bsdt_ctrl.sv
module bsdt_ctrl import bsdt_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  bsdt_status_t status,
  output bsdt_cmd_t    cmd
);

  typedef enum logic [2:0] {
    IDLE,
    EXEC,
    DIV,
    COMMIT,
    PUB
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = EXEC;
        end
      end
      EXEC: begin
        if (status.mode == MODE_TICK) begin
          cmd.tick   = 1'b1;
          state_next = PUB;
        end else begin
          cmd.rev    = 1'b1;
          state_next = status.late ? PUB : DIV;
        end
      end
      DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = COMMIT;
      end
      COMMIT: begin
        cmd.commit = 1'b1;
        state_next = PUB;
      end
      PUB: begin
        if (status.out_free) begin
          cmd.publish = 1'b1;
          state_next  = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  // An in-time revolution always runs the divider
  a_rev_to_div: assert property (@(posedge clk) disable iff (rst)
    state == EXEC && status.mode == MODE_REV && !status.late |=> state == DIV)
    else $error("in-time revolution skipped the divider");

  // The divider runs its full step count
  a_div_hold: assert property (@(posedge clk) disable iff (rst)
    state == DIV && !status.div_last |=> state == DIV)
    else $error("divider left early");

  // A waiting result blocks the return to idle
  a_pub_wait: assert property (@(posedge clk) disable iff (rst)
    state == PUB && !status.out_free |=> state == PUB)
    else $error("result dropped while output busy");

endmodule

### design/bsdt_dp.sv
module bsdt_dp import bsdt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  bsdt_cmd_t            cmd,
  output bsdt_status_t         status,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 mode,
  input  logic [RPM_W-1:0]     rpm,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [SPEED_W-1:0]   speed,
  output logic [DIST_W-1:0]    distance,
  output logic [TIME_W-1:0]    riding_ms,
  output logic                 timed_out
);

  logic [CFG_W-1:0] wheel_travel;
  logic [CFG_W-1:0] timeout_ms;
  logic [CFG_W-1:0] speed_falloff;

  logic [TIME_W-1:0]  now_ms;
  logic [TIME_W-1:0]  last_rev_time;
  logic [TIME_W-1:0]  next_rev_time;
  logic [SPEED_W-1:0] speed_reg;
  logic [DIST_W-1:0]  distance_reg;
  logic [TIME_W-1:0]  riding_time;
  logic               late_q;

  logic                  mode_q;
  logic [RPM_W-1:0]      rpm_q;
  logic [PROD_W-1:0]     prod;
  logic [QUOT_W-1:0]     quot;
  logic [RPM_W-1:0]      rem;
  logic [STEP_CNT_W-1:0] step_cnt;

  logic [TIME_W-1:0]  elapsed;
  logic               late_now;
  logic [TIME_W-1:0]  now_inc;
  logic [DIST_W:0]    dist_sum;
  logic [RPM60_W-1:0] rpm60;
  logic [RPM_W:0]     trial;
  logic               fits;
  logic               out_free;

  assign elapsed  = now_ms - last_rev_time;
  assign late_now = (elapsed >= {{(TIME_W-CFG_W){1'b0}}, timeout_ms});
  assign now_inc  = now_ms + 1'b1;
  assign dist_sum = {1'b0, distance_reg} + {{(DIST_W-CFG_W+1){1'b0}}, wheel_travel};
  assign rpm60    = RPM60_W'(rpm_q) * MIN_PER_HOUR;
  // restoring divide, one quotient bit per step
  assign trial    = {rem, quot[QUOT_W-1]};
  assign fits     = (trial >= {1'b0, rpm_q});
  assign out_free = !out_valid || !out_stall;

  assign status.mode     = mode_q;
  assign status.late     = late_now;
  assign status.div_last = (step_cnt == {STEP_CNT_W{1'b1}});
  assign status.out_free = out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_travel  <= DIST_PER_REV_RST;
      timeout_ms    <= TIMEOUT_MS_RST;
      speed_falloff <= SPEED_FALL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DIST_PER_REV: wheel_travel  <= cfg_data;
        REG_TIMEOUT_MS:   timeout_ms    <= cfg_data;
        REG_SPEED_FALL:   speed_falloff <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now_ms        <= '0;
      last_rev_time <= '0;
      next_rev_time <= '0;
      speed_reg     <= '0;
      distance_reg  <= '0;
      riding_time   <= '0;
      late_q        <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.tick) begin
        late_q <= 1'b0;
        now_ms <= now_inc;
        if (speed_reg != '0 && riding_time != {TIME_W{1'b1}})
          riding_time <= riding_time + 1'b1;
        if (now_inc > next_rev_time) begin
          if (speed_reg > {{(SPEED_W-CFG_W){1'b0}}, speed_falloff})
            speed_reg <= speed_reg - {{(SPEED_W-CFG_W){1'b0}}, speed_falloff};
          else
            speed_reg <= '0;
        end
      end
      if (cmd.rev) begin
        late_q        <= late_now;
        last_rev_time <= now_ms;
        if (late_now) begin
          speed_reg <= '0;
        end else begin
          distance_reg <= dist_sum[DIST_W] ? {DIST_W{1'b1}} : dist_sum[DIST_W-1:0];
        end
      end
      if (cmd.commit) begin
        speed_reg     <= prod[SPEED_SHIFT +: SPEED_W];
        next_rev_time <= (rpm_q == '0) ? '0 : now_ms + {{(TIME_W-QUOT_W){1'b0}}, quot};
      end
      if (cmd.publish) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // Item capture, multiplier, divider and output word: no reset needed
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q <= mode;
      rpm_q  <= rpm;
    end
    if (cmd.rev) begin
      prod     <= PROD_W'(rpm60) * PROD_W'(wheel_travel);
      quot     <= MS_PER_MINUTE + QUOT_W'(rpm_q >> 1);
      rem      <= '0;
      step_cnt <= '0;
    end
    if (cmd.div_step) begin
      rem      <= fits ? RPM_W'(trial - {1'b0, rpm_q}) : trial[RPM_W-1:0];
      quot     <= {quot[QUOT_W-2:0], fits};
      step_cnt <= step_cnt + 1'b1;
    end
    if (cmd.publish) begin
      speed     <= speed_reg;
      distance  <= distance_reg;
      riding_ms <= riding_time;
      timed_out <= late_q;
    end
  end

  a_pub_free: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> (!out_valid || !out_stall))
    else $error("output word overwritten while stalled");

  a_tick_no_rise: assert property (@(posedge clk) disable iff (rst)
    cmd.tick |=> speed_reg <= $past(speed_reg))
    else $error("speed rose on a tick");

  a_clock_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.tick |=> now_ms == $past(now_ms))
    else $error("clock moved without a tick");

endmodule

### design/bike_speed_distance_tracker_core.sv
// Bicycle computer core: speedometer, odometer and riding timer.
// Input channel (in_valid / in_stall): one word per event; mode 0 is a
// one-millisecond tick, mode 1 a wheel revolution report carrying rpm.
// Output channel (out_valid / out_stall): exactly one word per input word,
// holding speed (2^-16 mph), distance (2^-24 mile), riding_ms and timed_out.
// Configuration: cfg_we / cfg_index / cfg_data write distance_per_rev (0),
// timeout_ms (1) and speed_falloff (2); write only while the core is idle.
// Sequence: a tick goes from acceptance through execute to publish; an
// in-time revolution also runs the 16-step restoring divider that works
// out round(60000/rpm) and then commits; a late revolution skips the
// divider. One word is in work at a time; in_stall is high from acceptance
// until the result is loaded into the output register.
// The output register decouples the sides: a new word is accepted while the
// previous result waits. If the receiver stalls with a result still held,
// the next result waits in the controller and the input stays stalled.
// Reset (rst, synchronous) restores the register defaults, zeroes clock,
// speed, distance and riding time, and empties the output register.
module bike_speed_distance_tracker_core import bsdt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // input words
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 mode,
  input  logic [RPM_W-1:0]     rpm,
  // result words
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [SPEED_W-1:0]   speed,
  output logic [DIST_W-1:0]    distance,
  output logic [TIME_W-1:0]    riding_ms,
  output logic                 timed_out,
  // configuration writes
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  bsdt_cmd_t    cmd;
  bsdt_status_t status;

  // sequencer: capture, execute, divide, commit, publish
  bsdt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // state registers, multiplier, divider and output register
  bsdt_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mode      (mode),
    .rpm       (rpm),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .speed     (speed),
    .distance  (distance),
    .riding_ms (riding_ms),
    .timed_out (timed_out)
  );

endmodule

### dv/tb_bike_speed_distance_tracker_core.sv
module tb_bike_speed_distance_tracker_core;
  import bsdt_pkg::*;

  // ---------------------------------------------------------------------------
  // Clock, reset and block ports
  // ---------------------------------------------------------------------------
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 mode = MODE_TICK;
  logic [RPM_W-1:0]     rpm = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [SPEED_W-1:0]   speed;
  logic [DIST_W-1:0]    distance;
  logic [TIME_W-1:0]    riding_ms;
  logic                 timed_out;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_DIST_PER_REV;
  logic [CFG_W-1:0]     cfg_data = '0;

  always #4 clk = ~clk;

  bike_speed_distance_tracker_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .rpm       (rpm),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .speed     (speed),
    .distance  (distance),
    .riding_ms (riding_ms),
    .timed_out (timed_out),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // One result word as the rider would read it off the display
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [SPEED_W-1:0] spd;
    logic [DIST_W-1:0]  odo;
    logic [TIME_W-1:0]  ride;
    logic               late;
  } bike_reading_t;

  // Directed rows: either a word to send or a register write. A row marked
  // pinned carries a hand-worked reading; the rest go through the predictor.
  typedef enum logic {ROW_WORD, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;    // register rows only
    logic [CFG_W-1:0]     data;   // register rows only
    logic                 m;
    logic [RPM_W-1:0]     r;
    logic                 pinned;
    bike_reading_t        want;
  } plan_row_t;

  bike_reading_t readings_due [$];
  bike_reading_t head;
  plan_row_t     plan [$];
  int            n_bad = 0;
  bit            steady = 1'b0;   // no idling on either side while set

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the tracker's registers and settings
  // ---------------------------------------------------------------------------
  logic [TIME_W-1:0]  clock_ms    = '0;
  logic [TIME_W-1:0]  last_rev_ms = '0;
  logic [TIME_W-1:0]  next_rev_ms = '0;
  logic [SPEED_W-1:0] speed_q     = '0;
  logic [DIST_W-1:0]  odo_q       = '0;
  logic [TIME_W-1:0]  ride_q      = '0;
  logic [CFG_W-1:0]   wheel_step  = 16'd13307;
  logic [CFG_W-1:0]   rev_timeout = 16'd3000;
  logic [CFG_W-1:0]   decay_step  = 16'd33;

  // Advance the tracker by one word and return the reading it should show.
  function automatic bike_reading_t advance_bike(logic m, logic [RPM_W-1:0] r);
    bike_reading_t     res;
    logic [TIME_W-1:0] gap_ms;
    logic [DIST_W:0]   sum;
    logic [63:0]       prod;
    res = '0;
    if (m == MODE_TICK) begin
      clock_ms = clock_ms + 1'b1;
      // riding time counts on the speed before this tick's decay
      if (speed_q != '0 && ride_q != '1) ride_q = ride_q + 1'b1;
      // overdue test is a plain unsigned compare, no wrap correction
      if (clock_ms > next_rev_ms)
        speed_q = (speed_q > SPEED_W'(decay_step)) ? speed_q - SPEED_W'(decay_step) : '0;
    end else begin
      gap_ms = clock_ms - last_rev_ms;
      if (gap_ms < TIME_W'(rev_timeout)) begin
        sum   = {1'b0, odo_q} + (DIST_W+1)'(wheel_step);
        odo_q = sum[DIST_W] ? '1 : sum[DIST_W-1:0];
        prod  = 64'(r) * 64'd60 * 64'(wheel_step);
        speed_q = SPEED_W'(prod >> 8);
        // rounded 60000/rpm, halves up; zero rpm makes the next tick overdue
        next_rev_ms = (r != '0) ? clock_ms + (32'd60000 + 32'(r >> 1)) / 32'(r) : '0;
      end else begin
        speed_q  = '0;
        res.late = 1'b1;
      end
      last_rev_ms = clock_ms;
    end
    res.spd  = speed_q;
    res.odo  = odo_q;
    res.ride = ride_q;
    return res;
  endfunction

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (steady || pick < 55) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: drive at the falling edge, take acceptance at the rising edge
  // ---------------------------------------------------------------------------
  task automatic put_word(input logic m, input logic [RPM_W-1:0] r,
                          input bike_reading_t want);
    int gap;
    gap = gap_len();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    rpm      <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    readings_due.push_back(want);
  endtask

  // Stop sending and wait until every reading owed has come back.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write, only ever issued with the tracker idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_DIST_PER_REV: wheel_step  = d;
      REG_TIMEOUT_MS:   rev_timeout = d;
      REG_SPEED_FALL:   decay_step  = d;
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random back-pressure, with quiet spells while steady is set
  // ---------------------------------------------------------------------------
  initial begin
    int n;
    forever begin
      n = gap_len();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  end

  // Every word taken off the output is matched against the oldest reading owed.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (readings_due.size() == 0) begin
        $error("result word with no reading owed");
        n_bad++;
      end else begin
        head = readings_due.pop_front();
        if (speed !== head.spd) begin
          $error("speed: expected %0d, got %0d", head.spd, speed);
          n_bad++;
        end
        if (distance !== head.odo) begin
          $error("distance: expected %0d, got %0d", head.odo, distance);
          n_bad++;
        end
        if (riding_ms !== head.ride) begin
          $error("riding_ms: expected %0d, got %0d", head.ride, riding_ms);
          n_bad++;
        end
        if (timed_out !== head.late) begin
          $error("timed_out: expected %0d, got %0d", head.late, timed_out);
          n_bad++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int               sent;
    int               k;
    logic [RPM_W-1:0] r;
    bike_reading_t    want;

    // Directed walk. Default settings first: a tick straight out of reset,
    // a zero-rpm revolution, top rpm, one rpm, alternating rpm bits, a half
    // that rounds up (64 rpm -> 937.5 ms), then top speed at the widest
    // wheel, a zero timeout (every revolution late), a revolution at zero
    // elapsed time against a one-ms timeout, and the narrowest wheel.
    plan = '{
      '{ROW_WORD,  REG_DIST_PER_REV, 16'd0, MODE_TICK, 12'd0,    1'b1,
        {26'd0, 48'd0, 32'd0, 1'b0}},
      '{ROW_WORD,  REG_DIST_PER_REV, 16'd0, MODE_REV,  12'd0,    1'b1,
        {26'd0, 48'd13307, 32'd0, 1'b0}},
      '{ROW_WORD,  REG_DIST_PER_REV, 16'd0, MODE_TICK, 12'd0,    1'b0, '0},
      '{ROW_WORD,  REG_DIST_PER_REV, 16'd0, MODE_REV,  12'd4095, 1'b0, '0},
      '{ROW_WORD,  REG_DIST_PER_REV, 16'd0, MODE_TICK, 12'd4095, 1'b0, '0},
      '{ROW_WORD,  REG_DIST_PER_REV, 16'd0, MODE_TICK, 12'd0,    1'b0, '0},
      '{ROW_WORD,  REG_DIST_PER_REV, 16'd0, MODE_REV,  12'd1,    1'b0, '0},
      '{ROW_WORD,  REG_DIST_PER_REV, 16'd0, MODE_REV,  12'hAAA,  1'b0, '0},
      '{ROW_WORD,  REG_DIST_PER_REV, 16'd0, MODE_REV,  12'h555,  1'b0, '0},
      '{ROW_WORD,  REG_DIST_PER_REV, 16'd0, MODE_REV,  12'd64,   1'b0, '0},
      '{ROW_WORD,  REG_DIST_PER_REV, 16'd0, MODE_REV,  12'd2048, 1'b0, '0},
      '{ROW_WORD,  REG_DIST_PER_REV, 16'd0, MODE_TICK, 12'hFFF,  1'b0, '0},
      '{ROW_WRITE, REG_DIST_PER_REV, 16'hFFFF, MODE_TICK, 12'd0, 1'b0, '0},
      '{ROW_WRITE, REG_SPEED_FALL,   16'hFFFF, MODE_TICK, 12'd0, 1'b0, '0},
      '{ROW_WORD,  REG_DIST_PER_REV, 16'd0, MODE_REV,  12'd4095, 1'b0, '0},
      '{ROW_WORD,  REG_DIST_PER_REV, 16'd0, MODE_TICK, 12'd0,    1'b0, '0},
      '{ROW_WORD,  REG_DIST_PER_REV, 16'd0, MODE_TICK, 12'd0,    1'b0, '0},
      '{ROW_WRITE, REG_TIMEOUT_MS,   16'd0, MODE_TICK, 12'd0,    1'b0, '0},
      '{ROW_WORD,  REG_DIST_PER_REV, 16'd0, MODE_REV,  12'd100,  1'b0, '0},
      '{ROW_WRITE, REG_TIMEOUT_MS,   16'd1, MODE_TICK, 12'd0,    1'b0, '0},
      '{ROW_WRITE, REG_DIST_PER_REV, 16'd0, MODE_TICK, 12'd0,    1'b0, '0},
      '{ROW_WORD,  REG_DIST_PER_REV, 16'd0, MODE_REV,  12'd4095, 1'b0, '0},
      '{ROW_WORD,  REG_DIST_PER_REV, 16'd0, MODE_TICK, 12'd0,    1'b0, '0},
      '{ROW_WORD,  REG_DIST_PER_REV, 16'd0, MODE_TICK, 12'd0,    1'b0, '0},
      '{ROW_WRITE, REG_TIMEOUT_MS,   16'hFFFF, MODE_TICK, 12'd0, 1'b0, '0},
      '{ROW_WRITE, REG_SPEED_FALL,   16'd0, MODE_TICK, 12'd0,    1'b0, '0},
      '{ROW_WRITE, REG_DIST_PER_REV, 16'd1, MODE_TICK, 12'd0,    1'b0, '0},
      '{ROW_WORD,  REG_DIST_PER_REV, 16'd0, MODE_REV,  12'd4095, 1'b0, '0},
      '{ROW_WORD,  REG_DIST_PER_REV, 16'd0, MODE_TICK, 12'd0,    1'b0, '0},
      '{ROW_WORD,  REG_DIST_PER_REV, 16'd0, MODE_TICK, 12'd0,    1'b0, '0}
    };

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        drain();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        want = advance_bike(plan[i].m, plan[i].r);
        put_word(plan[i].m, plan[i].r, plan[i].pinned ? plan[i].want : want);
      end
    end

    // Random phases, each under its own settings. Most traffic is a revolution
    // followed by a run of ticks, so speed gets set, held, decays past the
    // expected time and, with short timeouts, restarts late. The odd stray
    // word of either kind with any rpm is mixed in.
    for (int p = 0; p < 6; p++) begin
      drain();
      case (p)
        0: begin
          write_reg(REG_DIST_PER_REV, 16'd13307);
          write_reg(REG_TIMEOUT_MS,   16'd3000);
          write_reg(REG_SPEED_FALL,   16'd33);
        end
        1: begin
          write_reg(REG_DIST_PER_REV, 16'hFFFF);
          write_reg(REG_TIMEOUT_MS,   16'd20);
          write_reg(REG_SPEED_FALL,   16'hFFFF);
        end
        2: begin
          write_reg(REG_DIST_PER_REV, 16'd0);
          write_reg(REG_TIMEOUT_MS,   16'd0);
          write_reg(REG_SPEED_FALL,   16'd0);
        end
        3: begin
          write_reg(REG_DIST_PER_REV, 16'd1);
          write_reg(REG_TIMEOUT_MS,   16'hFFFF);
          write_reg(REG_SPEED_FALL,   16'd1);
        end
        default: begin
          write_reg(REG_DIST_PER_REV, 16'($urandom_range(0, 65535)));
          write_reg(REG_TIMEOUT_MS, $urandom_range(0, 1) ?
                    16'($urandom_range(0, 80)) : 16'($urandom_range(0, 65535)));
          write_reg(REG_SPEED_FALL, 16'($urandom_range(0, 2000)));
        end
      endcase
      steady = (p == 1) || ($urandom_range(0, 3) == 0);
      sent = 0;
      while (sent < 60) begin
        if ($urandom_range(0, 9) == 0) begin
          // stray word
          r = RPM_W'($urandom_range(0, 4095));
          if ($urandom_range(0, 1) == 1) begin
            put_word(MODE_REV, r, advance_bike(MODE_REV, r));
          end else begin
            put_word(MODE_TICK, r, advance_bike(MODE_TICK, r));
          end
          sent++;
        end else begin
          k = $urandom_range(0, 99);
          if (k < 60)      r = RPM_W'($urandom_range(1000, 4095));
          else if (k < 80) r = RPM_W'($urandom_range(0, 4095));
          else if (k < 90) r = '0;
          else             r = RPM_W'($urandom_range(1, 40));
          put_word(MODE_REV, r, advance_bike(MODE_REV, r));
          sent++;
          k = ($urandom_range(0, 6) == 0) ? $urandom_range(30, 120) : $urandom_range(0, 20);
          repeat (k) begin
            r = RPM_W'($urandom_range(0, 4095));   // ignored on a tick
            put_word(MODE_TICK, r, advance_bike(MODE_TICK, r));
            sent++;
          end
        end
      end
    end

    drain();
    // a spell for any stray word to show up
    repeat (30) @(posedge clk);
    if (n_bad == 0 && readings_due.size() == 0) begin
      $display("tb_bike_speed_distance_tracker_core OK");
    end else begin
      $display("tb_bike_speed_distance_tracker_core NOT OK");
    end
    $finish;
  end

  // Hang guard, well beyond the slowest legal run
  initial begin
    #5000000;
    $display("tb_bike_speed_distance_tracker_core NOT OK");
    $finish;
  end

endmodule
